### hw/rtl/mandelbrot_escape_count_top_defines.svh
// assertion macros used by the checker file
`ifndef MANDELBROT_ESCAPE_COUNT_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_COUNT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define MEC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mec checker: same-cycle property failed");

// next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define MEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mec checker: next-cycle property failed");

`endif

### hw/rtl/mec_pkg.sv
package mec_pkg;

  // fixed widths of the words and the fixed-point formats
  localparam int unsigned QW       = 32;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned CountW   = 11;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned ProdW    = 44;
  localparam int unsigned PMagW    = 42;
  localparam int unsigned DivCntW  = 2;
  localparam int unsigned WideW    = 48;
  localparam int unsigned SqW      = 64;
  localparam int unsigned FracBits = 28;

  // |z|^2 escape bound, 4.0 in Q8.56
  localparam logic [SqW:0] EscapeQ56 = 65'h0_0400_0000_0000_0000;

  // saturation bounds in the wide format
  localparam logic signed [WideW-1:0] QMax = 48'sh0000_7FFF_FFFF;
  localparam logic signed [WideW-1:0] QMin = 48'shFFFF_8000_0000;

  // register reset values, Q4.28
  localparam logic [QW-1:0] RealMinReset = 32'hE800_0000;
  localparam logic [QW-1:0] RealMaxReset = 32'h0800_0000;
  localparam logic [QW-1:0] ImagMinReset = 32'hF000_0000;
  localparam logic [QW-1:0] ImagMaxReset = 32'h1000_0000;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REAL_MIN = 8'd0,
    CFG_REAL_MAX = 8'd1,
    CFG_IMAG_MIN = 8'd2,
    CFG_IMAG_MAX = 8'd3
  } cfg_reg_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic prod;
    logic div_step;
    logic fin;
    logic mul;
    logic upd;
    logic out_load;
    logic axis;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
    logic escaped;
    logic at_limit;
  } sts_t;

  // clamp a wide signed value to the Q4.28 range
  function automatic logic [QW-1:0] sat_q(input logic signed [WideW-1:0] v);
    logic [QW-1:0] res;
    if (v > QMax) begin
      res = 32'h7FFF_FFFF;
    end else if (v < QMin) begin
      res = 32'h8000_0000;
    end else begin
      res = v[QW-1:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/mec_div.sv
module mec_div #(
  parameter int unsigned DIVISOR_A = 1024,
  parameter int unsigned DIVISOR_B = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       step_i,
  input  logic                       sel_i,
  input  logic [mec_pkg::PMagW-1:0]  dividend_i,
  output logic [mec_pkg::PMagW-1:0]  quot_o,
  output logic                       last_o
);

  // dividend and reciprocal split in halves, full product width
  localparam int unsigned XW   = mec_pkg::PMagW;
  localparam int unsigned XLoW = XW / 2;
  localparam int unsigned MW   = XW + 1;
  localparam int unsigned MLoW = (MW + 1) / 2;
  localparam int unsigned PpW  = XLoW + MLoW;
  localparam int unsigned AccW = XW + MW;

  // reciprocals ceil(2^sh / d), exact for every dividend below 2^XW
  localparam int unsigned ShA = XW + $clog2(DIVISOR_A);
  localparam int unsigned ShB = XW + $clog2(DIVISOR_B);
  localparam logic [63:0] RecipA =
    ((64'd1 << ShA) + 64'(DIVISOR_A) - 64'd1) / 64'(DIVISOR_A);
  localparam logic [63:0] RecipB =
    ((64'd1 << ShB) + 64'(DIVISOR_B) - 64'd1) / 64'(DIVISOR_B);

  logic [XW-1:0]               x_q, x_d;
  logic [AccW-1:0]             acc_q, acc_d;
  logic [mec_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        sel_q, sel_d;
  logic [MW-1:0]               recip;
  logic [XLoW-1:0]             x_part;
  logic [MLoW-1:0]             m_part;
  logic [PpW-1:0]              pp;
  logic [AccW-1:0]             pp_sh;
  logic [AccW-1:0]             acc_sh;

  // one partial product per step: bit 1 picks the dividend half, bit 0 the reciprocal half
  assign recip  = sel_q ? RecipB[MW-1:0] : RecipA[MW-1:0];
  assign x_part = cnt_q[1] ? x_q[XW-1:XLoW] : x_q[XLoW-1:0];
  assign m_part = cnt_q[0] ? MLoW'(recip[MW-1:MLoW]) : recip[MLoW-1:0];
  assign pp     = x_part * m_part;

  always_comb begin
    unique case (cnt_q)
      2'd0: pp_sh = AccW'(pp);
      2'd1: pp_sh = AccW'(pp) << MLoW;
      2'd2: pp_sh = AccW'(pp) << XLoW;
      2'd3: pp_sh = AccW'(pp) << (XLoW + MLoW);
    endcase
  end

  always_comb begin
    x_d   = x_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    sel_d = sel_q;
    if (start_i) begin
      x_d   = dividend_i;
      acc_d = '0;
      cnt_d = '0;
      sel_d = sel_i;
    end else if (step_i) begin
      acc_d = acc_q + pp_sh;
      cnt_d = cnt_q + 1'b1;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // dividend, accumulator and divisor choice
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    sel_q <= sel_d;
  end

  // quotient is the product scaled back down
  assign acc_sh = sel_q ? (acc_q >> ShB) : (acc_q >> ShA);
  assign quot_o = acc_sh[XW-1:0];
  assign last_o = (cnt_q == '1);

endmodule

### hw/rtl/mec_ctrl.sv
module mec_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mec_pkg::cmd_t cmd_o,
  input  mec_pkg::sts_t sts_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_PROD  = 7'b000_0010,
    ST_DIV   = 7'b000_0100,
    ST_FIN   = 7'b000_1000,
    ST_MUL   = 7'b001_0000,
    ST_UPD   = 7'b010_0000,
    ST_DONE  = 7'b100_0000
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register may be refilled when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = 1'b0;
          state_d    = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = ST_PROD;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        if (sts_i.escaped || sts_i.at_limit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/mec_datapath.sv
module mec_datapath #(
  parameter int unsigned IMAGE_WIDTH    = 1024,
  parameter int unsigned IMAGE_HEIGHT   = 1024,
  parameter int unsigned MAX_ITERATIONS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mec_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mec_pkg::QW-1:0]        cfg_data_i,
  input  logic [mec_pkg::IdxW-1:0]      pixel_col_i,
  input  logic [mec_pkg::IdxW-1:0]      pixel_row_i,
  input  mec_pkg::cmd_t                 cmd_i,
  output mec_pkg::sts_t                 sts_o,
  output logic [mec_pkg::CountW-1:0]    iter_count_o
);

  localparam int unsigned NW = $clog2(MAX_ITERATIONS + 1);

  // box registers
  logic [mec_pkg::QW-1:0] real_min_q, real_max_q, imag_min_q, imag_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_min_q <= mec_pkg::RealMinReset;
      real_max_q <= mec_pkg::RealMaxReset;
      imag_min_q <= mec_pkg::ImagMinReset;
      imag_max_q <= mec_pkg::ImagMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mec_pkg::CFG_REAL_MIN: real_min_q <= cfg_data_i;
        mec_pkg::CFG_REAL_MAX: real_max_q <= cfg_data_i;
        mec_pkg::CFG_IMAG_MIN: imag_min_q <= cfg_data_i;
        mec_pkg::CFG_IMAG_MAX: imag_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pixel word
  logic [mec_pkg::IdxW-1:0] col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
  end

  // coordinate mapping: p = (max - min) * index, then p / size
  logic [mec_pkg::QW-1:0]              lo, hi;
  logic [mec_pkg::IdxW-1:0]            idx;
  logic signed [mec_pkg::QW:0]         span;
  logic signed [mec_pkg::ProdW-1:0]    prod;
  logic [mec_pkg::ProdW-1:0]           prod_mag;
  logic                                p_neg_q;
  logic [mec_pkg::PMagW-1:0]           quot;
  logic                                div_last;

  assign lo       = cmd_i.axis ? imag_min_q : real_min_q;
  assign hi       = cmd_i.axis ? imag_max_q : real_max_q;
  assign idx      = cmd_i.axis ? row_q : col_q;
  assign span     = $signed({hi[mec_pkg::QW-1], hi}) - $signed({lo[mec_pkg::QW-1], lo});
  assign prod     = span * $signed({1'b0, idx});
  assign prod_mag = prod[mec_pkg::ProdW-1] ? -prod : prod;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      p_neg_q <= prod[mec_pkg::ProdW-1];
    end
  end

  mec_div #(
    .DIVISOR_A (IMAGE_WIDTH),
    .DIVISOR_B (IMAGE_HEIGHT)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.prod),
    .step_i     (cmd_i.div_step),
    .sel_i      (cmd_i.axis),
    .dividend_i (prod_mag[mec_pkg::PMagW-1:0]),
    .quot_o     (quot),
    .last_o     (div_last)
  );

  // c = min + quotient, truncated toward zero, saturated
  logic signed [mec_pkg::WideW-1:0] q_wide, q_signed, c_sum;
  logic [mec_pkg::QW-1:0]           cr_q, ci_q;

  assign q_wide   = $signed({{(mec_pkg::WideW - mec_pkg::PMagW){1'b0}}, quot});
  assign q_signed = p_neg_q ? -q_wide : q_wide;
  assign c_sum    = $signed({{(mec_pkg::WideW - mec_pkg::QW){lo[mec_pkg::QW-1]}}, lo})
                    + q_signed;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (cmd_i.axis) begin
        ci_q <= mec_pkg::sat_q(c_sum);
      end else begin
        cr_q <= mec_pkg::sat_q(c_sum);
      end
    end
  end

  // iteration: products, then escape test and update
  logic signed [mec_pkg::QW-1:0]    r_q, s_q;
  logic [mec_pkg::SqW-1:0]          rr_q, ss_q;
  logic signed [mec_pkg::SqW-1:0]   rs_q;
  logic [NW-1:0]                    n_q;
  logic [mec_pkg::SqW:0]            mag_sq;
  logic                             escaped;
  logic signed [mec_pkg::SqW-1:0]   re_diff, re_sh, im_sh;
  logic signed [mec_pkg::WideW-1:0] re_next, im_next;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rr_q <= r_q * r_q;
      ss_q <= s_q * s_q;
      rs_q <= r_q * s_q;
    end
  end

  assign mag_sq  = {1'b0, rr_q} + {1'b0, ss_q};
  assign escaped = (mag_sq > mec_pkg::EscapeQ56);
  assign re_diff = $signed(rr_q) - $signed(ss_q);
  assign re_sh   = re_diff >>> mec_pkg::FracBits;
  assign im_sh   = rs_q >>> (mec_pkg::FracBits - 1);
  assign re_next = re_sh[mec_pkg::WideW-1:0]
                   + $signed({{(mec_pkg::WideW - mec_pkg::QW){cr_q[mec_pkg::QW-1]}}, cr_q});
  assign im_next = im_sh[mec_pkg::WideW-1:0]
                   + $signed({{(mec_pkg::WideW - mec_pkg::QW){ci_q[mec_pkg::QW-1]}}, ci_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= '0;
      s_q <= '0;
      n_q <= '0;
    end else if (cmd_i.upd && !escaped) begin
      r_q <= mec_pkg::sat_q(re_next);
      s_q <= mec_pkg::sat_q(im_next);
      n_q <= n_q + 1'b1;
    end
  end

  // result word, low bits of the count
  logic [NW+mec_pkg::CountW-1:0] n_ext;
  logic [mec_pkg::CountW-1:0]    count_q;

  assign n_ext = {{mec_pkg::CountW{1'b0}}, n_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      count_q <= n_ext[mec_pkg::CountW-1:0];
    end
  end

  assign iter_count_o   = count_q;
  assign sts_o.div_last = div_last;
  assign sts_o.escaped  = escaped;
  assign sts_o.at_limit = (n_q == NW'(MAX_ITERATIONS - 1));

endmodule

### hw/rtl/mandelbrot_escape_count_top.sv
// Mandelbrot escape-time counter, Q4.28 fixed point.
// Input channel (in_valid_i / in_stall_o): one word per pixel, column and row.
// The pixel is mapped into the box held in four registers, then z = z^2 + c
// runs from zero until |z|^2 > 4 or MAX_ITERATIONS is reached.
// Output channel (out_valid_o / out_stall_i): one word per pixel, the count.
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0..3 selects
// real_min, real_max, imag_min, imag_max; other indexes are ignored. Write
// only while the block is idle; cfg_ready_o is always high.
// One pixel is in work at a time. Each axis of the mapping takes a product,
// four reciprocal multiply steps and a sum; each iteration takes the
// products, then the escape test and update. A pixel that reaches the limit
// takes the longest. The next pixel can be accepted in the cycle after the
// count is loaded.
// The output register lets the next pixel be accepted while a count waits;
// a stalled receiver holds the word, and a second finished count waits in
// the core until the register is free, with in_stall_o high meanwhile.
// Reset loads the default box (-1.5..0.5, -1.0..1.0) and empties the block.
module mandelbrot_escape_count_top #(
  parameter int unsigned IMAGE_WIDTH    = 1024,
  parameter int unsigned IMAGE_HEIGHT   = 1024,
  parameter int unsigned MAX_ITERATIONS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mec_pkg::IdxW-1:0]    pixel_col_i,
  input  logic [mec_pkg::IdxW-1:0]    pixel_row_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mec_pkg::CountW-1:0]  iter_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mec_pkg::QW-1:0]      cfg_data_i
);

  mec_pkg::cmd_t cmd;
  mec_pkg::sts_t sts;
  logic          cfg_we;

  // register writes never wait
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  mec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mec_datapath #(
    .IMAGE_WIDTH    (IMAGE_WIDTH),
    .IMAGE_HEIGHT   (IMAGE_HEIGHT),
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .iter_count_o (iter_count_o)
  );

endmodule

### hw/rtl/mec_checker.sv
`include "mandelbrot_escape_count_top_defines.svh"

module mec_checker #(
  parameter int unsigned MAX_ITERATIONS = 1024
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [mec_pkg::CountW-1:0] iter_count_o
);

  // a pending count stays offered while the receiver stalls
  `MEC_ASSERT_NEXT(a_out_hold_valid, out_valid_o && out_stall_i, out_valid_o)

  // and its word does not move
  `MEC_ASSERT_NEXT(a_out_hold_word, out_valid_o && out_stall_i, $stable(iter_count_o))

  // one pixel at a time: the cycle after acceptance the input is stalled
  `MEC_ASSERT_NEXT(a_one_in_work, in_valid_i && !in_stall_o, in_stall_o)

  // a count never exceeds the iteration limit unless it wraps
  `MEC_ASSERT_IMPLIES(a_count_range, out_valid_o, (MAX_ITERATIONS > 2047) || ({6'b0, iter_count_o} <= 17'(MAX_ITERATIONS)))

endmodule

bind mandelbrot_escape_count_top mec_checker #(
  .MAX_ITERATIONS (MAX_ITERATIONS)
) u_mec_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .iter_count_o (iter_count_o)
);
